### src/etimer_pkg.sv
// ----------------------------------------------------------------------------
// Event timer table package
// Shared widths, codes, state encoding and controller/datapath structs.
// ----------------------------------------------------------------------------
package etimer_pkg;

  localparam int KIND_W   = 3;
  localparam int TYPE_W   = 8;
  localparam int ID_W     = 32;
  localparam int TIME_W   = 32;
  localparam int SIDX_W   = 4;
  localparam int STATUS_W = 3;

  localparam logic [TYPE_W-1:0] RENDER_TYPE_RESET = 8'd1;

  typedef enum logic [KIND_W-1:0] {
    K_CREATE      = 3'd0,
    K_FREE        = 3'd1,
    K_FIND        = 3'd2,
    K_PROC_NORMAL = 3'd3,
    K_PROC_RENDER = 3'd4,
    K_CLEAR       = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_UNUSED   = 3'd3,
    ST_FIRED    = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_FIND,
    S_PROC,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_IDX,
    SRC_REQ
  } slot_src_t;

  typedef struct packed {
    logic      in_ready;
    logic      load_req;
    logic      idx_inc;
    logic      emit;
    status_t   emit_status;
    slot_src_t slot_src;
    logic      ram_wr;
    logic      set_used;
    logic      clr_used_idx;
    logic      clr_used_req;
    logic      clr_all;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic used_idx;
    logic id_match;
    logic fire_hit;
    logic out_free;
    logic free_ok;
  } dp_sts_t;

endpackage

### src/etimer_if.sv
// ----------------------------------------------------------------------------
// Event timer table channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface etimer_in_if import etimer_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [TYPE_W-1:0]        event_type;
  logic signed [ID_W-1:0]   event_id;
  logic [TIME_W-1:0]        delay;
  logic [TIME_W-1:0]        now;
  logic [SIDX_W-1:0]        slot_index;

  modport source (output valid, kind, event_type, event_id, delay, now, slot_index,
                  input ready);
  modport sink   (input valid, kind, event_type, event_id, delay, now, slot_index,
                  output ready);
endinterface

interface etimer_out_if import etimer_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [SIDX_W-1:0]        slot;
  logic signed [ID_W-1:0]   fired_id;
  logic [TYPE_W-1:0]        fired_type;
  logic                     last;

  modport source (output valid, status, slot, fired_id, fired_type, last,
                  input ready);
  modport sink   (input valid, status, slot, fired_id, fired_type, last,
                  output ready);
endinterface

### src/etimer_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module etimer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/etimer_ctrl.sv
// ----------------------------------------------------------------------------
// Event timer table controller
// Sequences request handling and the slot-by-slot scans.
// ----------------------------------------------------------------------------
module etimer_ctrl import etimer_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  input  dp_sts_t           sts,
  output ctrl_cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && sts.out_free && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            K_CREATE:      state_nxt = S_CREATE;
            K_FIND:        state_nxt = S_FIND;
            K_PROC_NORMAL,
            K_PROC_RENDER: state_nxt = S_PROC;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_CREATE: begin
        if ((!sts.used_idx || sts.idx_last) && sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIND: begin
        if ((sts.id_match || sts.idx_last) && sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_PROC: begin
        if (sts.idx_last && (!sts.fire_hit || sts.out_free)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.emit_status = ST_OK;
    cmd.slot_src    = SRC_ZERO;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = sts.out_free && rst_n;
        if (accept) begin
          cmd.load_req = 1'b1;
          unique case (in_kind)
            K_FREE: begin
              cmd.emit         = 1'b1;
              cmd.emit_status  = sts.free_ok ? ST_OK : ST_UNUSED;
              cmd.slot_src     = SRC_REQ;
              cmd.clr_used_req = sts.free_ok;
            end
            K_CLEAR: begin
              cmd.emit    = 1'b1;
              cmd.clr_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_CREATE: begin
        if (!sts.used_idx) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.slot_src = SRC_IDX;
            cmd.ram_wr   = 1'b1;
            cmd.set_used = 1'b1;
          end
        end else if (sts.idx_last) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_FULL;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FIND: begin
        if (sts.id_match) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.slot_src = SRC_IDX;
          end
        end else if (sts.idx_last) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_NOTFOUND;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PROC: begin
        if (sts.fire_hit) begin
          if (sts.out_free) begin
            cmd.emit         = 1'b1;
            cmd.emit_status  = ST_FIRED;
            cmd.slot_src     = SRC_IDX;
            cmd.clr_used_idx = 1'b1;
            cmd.idx_inc      = !sts.idx_last;
          end
        end else begin
          cmd.idx_inc = !sts.idx_last;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_DONE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/etimer_dp.sv
// ----------------------------------------------------------------------------
// Event timer table datapath
// Request registers, slot table, scan index and result register.
// ----------------------------------------------------------------------------
module etimer_dp import etimer_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              cmd,
  output dp_sts_t                sts,
  input  logic                   cfg_we,
  input  logic [TYPE_W-1:0]      cfg_wdata,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [TYPE_W-1:0]      in_event_type,
  input  logic signed [ID_W-1:0] in_event_id,
  input  logic [TIME_W-1:0]      in_delay,
  input  logic [TIME_W-1:0]      in_now,
  input  logic [SIDX_W-1:0]      in_slot_index,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [SIDX_W-1:0]      out_slot,
  output logic signed [ID_W-1:0] out_fired_id,
  output logic [TYPE_W-1:0]      out_fired_type,
  output logic                   out_last
);

  localparam int IW = $clog2(SLOTS);
  localparam int RW = TYPE_W + ID_W + TIME_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  logic [TYPE_W-1:0]      render_type_r;
  logic [TYPE_W-1:0]      req_type_r;
  logic [ID_W-1:0]        req_id_r;
  logic [TIME_W-1:0]      req_deadline_r;
  logic [TIME_W-1:0]      req_now_r;
  logic                   req_render_r;
  logic [IW-1:0]          idx_r;
  logic [SLOTS-1:0]       used_r;
  logic [SLOTS-1:0]       used_nxt;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [SIDX_W-1:0]      out_slot_r;
  logic [ID_W-1:0]        out_fired_id_r;
  logic [TYPE_W-1:0]      out_fired_type_r;
  logic                   out_last_r;

  logic [TIME_W:0]        dl_sum;
  logic [TIME_W-1:0]      dl_sat;
  logic [IW-1:0]          raddr;
  logic [RW-1:0]          rdata;
  logic [TYPE_W-1:0]      rd_type;
  logic [ID_W-1:0]        rd_id;
  logic [TIME_W-1:0]      rd_deadline;
  logic [IW-1:0]          free_idx;
  logic                   free_in_range;
  logic [SIDX_W-1:0]      emit_slot;
  logic                   emit_fired;

  assign dl_sum = {1'b0, in_now} + {1'b0, in_delay};
  assign dl_sat = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

  assign raddr = cmd.load_req ? '0 : (cmd.idx_inc ? idx_r + 1'b1 : idx_r);

  etimer_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .waddr (idx_r),
    .wdata ({req_type_r, req_id_r, req_deadline_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign {rd_type, rd_id, rd_deadline} = rdata;

  assign free_in_range = (32'(in_slot_index) < 32'(SLOTS));
  assign free_idx      = IW'(in_slot_index);

  assign sts.idx_last = (idx_r == IDX_LAST);
  assign sts.used_idx = used_r[idx_r];
  assign sts.id_match = used_r[idx_r] && (rd_id == req_id_r);
  assign sts.fire_hit = used_r[idx_r] && ((rd_type == render_type_r) == req_render_r)
                        && (rd_deadline <= req_now_r);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.free_ok  = free_in_range && used_r[free_idx];

  always_comb begin
    used_nxt = used_r;
    if (cmd.clr_all) begin
      used_nxt = '0;
    end else begin
      if (cmd.set_used) begin
        used_nxt[idx_r] = 1'b1;
      end
      if (cmd.clr_used_idx) begin
        used_nxt[idx_r] = 1'b0;
      end
      if (cmd.clr_used_req) begin
        used_nxt[free_idx] = 1'b0;
      end
    end
  end

  always_comb begin
    unique case (cmd.slot_src)
      SRC_IDX: emit_slot = SIDX_W'(idx_r);
      SRC_REQ: emit_slot = in_slot_index;
      default: emit_slot = '0;
    endcase
  end

  assign emit_fired = (cmd.emit_status == ST_FIRED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      render_type_r <= RENDER_TYPE_RESET;
      used_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        render_type_r <= cfg_wdata;
      end
      used_r <= used_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r     <= in_event_type;
      req_id_r       <= in_event_id;
      req_deadline_r <= dl_sat;
      req_now_r      <= in_now;
      req_render_r   <= (in_kind == K_PROC_RENDER);
      idx_r          <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.emit) begin
      out_status_r     <= cmd.emit_status;
      out_slot_r       <= emit_slot;
      out_fired_id_r   <= emit_fired ? rd_id : '0;
      out_fired_type_r <= emit_fired ? rd_type : '0;
      out_last_r       <= !emit_fired;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_fired_id   = out_fired_id_r;
  assign out_fired_type = out_fired_type_r;
  assign out_last       = out_last_r;

endmodule

### src/event_timer_table_top.sv
// ----------------------------------------------------------------------------
// Event timer table
// A table of SLOTS timed events with create, free, find, process and clear.
//
//   Channel | Direction | Transfer
//   in_ch   | sink      | one request (kind, type, id, delay, now, slot index)
//   out_ch  | source    | one result (status, slot, fired id/type, last)
//   cfg     | write     | render_type, on cfg_we
//
// Free, clear and unknown kinds are handled without a scan. Create scans past each
// occupied slot ahead of the first free one, and over the whole table when it is full.
// Find visits slots from slot 0 until a match or the last slot.
// Process visits all SLOTS slots and then gives the done result.
// A stalled result register holds a scan only at a slot with a result to give.
// Reset is synchronous and leaves every slot unused.
// ----------------------------------------------------------------------------
module event_timer_table_top import etimer_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  etimer_in_if.sink          in_ch,
  etimer_out_if.source       out_ch,
  input  logic               cfg_we,
  input  logic [TYPE_W-1:0]  cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  etimer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  etimer_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_ch.kind),
    .in_event_type  (in_ch.event_type),
    .in_event_id    (in_ch.event_id),
    .in_delay       (in_ch.delay),
    .in_now         (in_ch.now),
    .in_slot_index  (in_ch.slot_index),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_slot       (out_ch.slot),
    .out_fired_id   (out_ch.fired_id),
    .out_fired_type (out_ch.fired_type),
    .out_last       (out_ch.last)
  );

  assign in_ch.ready = cmd.in_ready;

endmodule

### src/etimer_checker.sv
// ----------------------------------------------------------------------------
// Event timer table checker
// Port-level assertions on request and result behavior, bound to the top.
// ----------------------------------------------------------------------------
module etimer_checker import etimer_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [KIND_W-1:0]   in_kind,
  input logic [SIDX_W-1:0]   in_slot_index,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [SIDX_W-1:0]   out_slot,
  input logic                out_last
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("Result changed or dropped while stalled.");

  a_free_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_kind == K_FREE |=>
      out_valid && out_last && out_slot == $past(in_slot_index)
      && (out_status == ST_OK || out_status == ST_UNUSED))
    else $error("Free transfer did not produce its result on the next cycle.");

  a_unknown_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_kind == 3'd6 || in_kind == 3'd7) |=> !out_valid)
    else $error("Unknown request produced a result.");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_status != ST_FIRED)))
    else $error("Last flag does not match the result status.");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_kind == K_FIND || in_kind == K_PROC_NORMAL
                || in_kind == K_PROC_RENDER) |=> !in_ready)
    else $error("New request taken while a scan is in progress.");

endmodule

bind event_timer_table_top etimer_checker u_etimer_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_kind       (in_ch.kind),
  .in_slot_index (in_ch.slot_index),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_slot      (out_ch.slot),
  .out_last      (out_ch.last)
);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Event timer table testbench
// Drives create, free, find, process and clear requests into the timer table,
// predicts every result from a private copy of the table, and checks each
// result transfer field by field. The render type is rewritten between phases.
// Both channels idle at random, first mostly on the result side, then mostly
// on the request side, then not at all.
// ----------------------------------------------------------------------------
module tb_top import etimer_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam logic [KIND_W-1:0] K_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES = 2 * SLOTS;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TYPE_W-1:0] event_type;
    logic [ID_W-1:0]   event_id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] now;
    logic [SIDX_W-1:0] slot_index;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SIDX_W-1:0]   slot;
    logic [ID_W-1:0]     fired_id;
    logic [TYPE_W-1:0]   fired_type;
    logic                last;
  } result_t;

  class event_table_scoreboard;
    logic [TYPE_W-1:0] render_type;
    bit                used[SLOTS];
    logic [TYPE_W-1:0] ev_type[SLOTS];
    logic [ID_W-1:0]   ev_id[SLOTS];
    logic [TIME_W-1:0] deadline[SLOTS];
    result_t           awaited_results[$];
    int                errors;

    function new();
      render_type = RENDER_TYPE_RESET;
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void owe(status_t st, int sl, logic [ID_W-1:0] id,
                      logic [TYPE_W-1:0] ty, logic last);
      result_t r;
      r.status = st;
      r.slot = SIDX_W'(sl);
      r.fired_id = id;
      r.fired_type = ty;
      r.last = last;
      awaited_results.push_back(r);
    endfunction

    function void apply_request(request_t r);
      logic [TIME_W:0] sum;
      logic [TIME_W-1:0] dl;
      bit want_render;
      bit done;
      done = 1'b0;
      case (r.kind)
        K_CREATE: begin
          sum = {1'b0, r.now} + {1'b0, r.delay};
          dl = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
          for (int i = 0; i < SLOTS && !done; i++) begin
            if (!used[i]) begin
              used[i] = 1'b1;
              ev_type[i] = r.event_type;
              ev_id[i] = r.event_id;
              deadline[i] = dl;
              owe(ST_OK, i, '0, '0, 1'b1);
              done = 1'b1;
            end
          end
          if (!done) owe(ST_FULL, 0, '0, '0, 1'b1);
        end
        K_FREE: begin
          if (int'(r.slot_index) < SLOTS && used[r.slot_index]) begin
            used[r.slot_index] = 1'b0;
            owe(ST_OK, r.slot_index, '0, '0, 1'b1);
          end else begin
            owe(ST_UNUSED, r.slot_index, '0, '0, 1'b1);
          end
        end
        K_FIND: begin
          for (int i = 0; i < SLOTS && !done; i++) begin
            if (used[i] && ev_id[i] == r.event_id) begin
              owe(ST_OK, i, '0, '0, 1'b1);
              done = 1'b1;
            end
          end
          if (!done) owe(ST_NOTFOUND, 0, '0, '0, 1'b1);
        end
        K_PROC_NORMAL, K_PROC_RENDER: begin
          want_render = (r.kind == K_PROC_RENDER);
          for (int i = 0; i < SLOTS; i++) begin
            if (used[i] && ((ev_type[i] == render_type) == want_render) &&
                deadline[i] <= r.now) begin
              owe(ST_FIRED, i, ev_id[i], ev_type[i], 1'b0);
              used[i] = 1'b0;
            end
          end
          owe(ST_DONE, 0, '0, '0, 1'b1);
        end
        K_CLEAR: begin
          foreach (used[i]) used[i] = 1'b0;
          owe(ST_OK, 0, '0, '0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result status %0d slot %0d", got.status, got.slot));
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, predicted %0d", got.status, want.status));
        if (got.slot !== want.slot)
          report($sformatf("slot %0d, predicted %0d", got.slot, want.slot));
        if (got.fired_id !== want.fired_id)
          report($sformatf("fired_id %h, predicted %h", got.fired_id, want.fired_id));
        if (got.fired_type !== want.fired_type)
          report($sformatf("fired_type %0d, predicted %0d", got.fired_type,
                           want.fired_type));
        if (got.last !== want.last)
          report($sformatf("last %0d, predicted %0d", got.last, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TYPE_W-1:0] cfg_wdata;

  etimer_in_if  in_ch();
  etimer_out_if out_ch();

  event_table_scoreboard sb = new();

  int snd_idle_pct;
  int rcv_idle_pct;
  logic [TIME_W-1:0] tick;
  logic [ID_W-1:0] id_pool[8];

  event_timer_table_top #(.SLOTS(SLOTS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.slot = out_ch.slot;
        got.fired_id = out_ch.fired_id;
        got.fired_type = out_ch.fired_type;
        got.last = out_ch.last;
        sb.check_result(got);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic send_request(request_t r);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= r.kind;
    in_ch.event_type <= r.event_type;
    in_ch.event_id   <= r.event_id;
    in_ch.delay      <= r.delay;
    in_ch.now        <= r.now;
    in_ch.slot_index <= r.slot_index;
    do @(posedge clk); while (!in_ch.ready);
    sb.apply_request(r);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_render_type(logic [TYPE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.render_type = value;
  endtask

  function automatic request_t noise_request(logic [KIND_W-1:0] kind);
    request_t r;
    r.kind = kind;
    r.event_type = TYPE_W'($urandom);
    r.event_id = $urandom;
    r.delay = $urandom;
    r.now = $urandom;
    r.slot_index = SIDX_W'($urandom);
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] pick_now();
    tick += $urandom_range(0, 6);
    return ($urandom_range(0, 99) < 10) ? TIME_W'($urandom) : tick;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] id;
    if ($urandom_range(0, 99) < 60) return id_pool[$urandom_range(0, 7)];
    id = $urandom;
    if ($urandom_range(0, 3) == 0) id_pool[$urandom_range(0, 7)] = id;
    return id;
  endfunction

  function automatic request_t random_request(logic [KIND_W-1:0] kind);
    request_t r;
    int w;
    r = noise_request(kind);
    case (kind)
      K_CREATE: begin
        w = $urandom_range(0, 99);
        if (w < 45) r.event_type = sb.render_type;
        else if (w < 75) r.event_type = TYPE_W'($urandom_range(0, 3));
        w = $urandom_range(0, 99);
        if (w < 60) r.delay = $urandom_range(0, 30);
        else if (w < 75) r.delay = '0;
        else if (w < 90) r.delay = $urandom;
        else r.delay = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3));
        r.event_id = pick_id();
        r.now = pick_now();
      end
      K_FIND: r.event_id = pick_id();
      K_PROC_NORMAL, K_PROC_RENDER: r.now = pick_now();
      default: ;
    endcase
    return r;
  endfunction

  task automatic run_random(int count);
    int sent;
    int w;
    logic [KIND_W-1:0] kind;
    sent = 0;
    while (sent < count) begin
      w = $urandom_range(0, 99);
      if (w < 5) begin
        repeat ($urandom_range(8, SLOTS + 1)) begin
          send_request(random_request(K_CREATE));
          sent++;
        end
      end else begin
        if (w < 35) kind = K_CREATE;
        else if (w < 50) kind = K_FREE;
        else if (w < 63) kind = K_FIND;
        else if (w < 76) kind = K_PROC_NORMAL;
        else if (w < 89) kind = K_PROC_RENDER;
        else if (w < 93) kind = K_CLEAR;
        else kind = $urandom_range(0, 1) ? K_SPARE_A : K_SPARE_B;
        send_request(random_request(kind));
        if (kind != K_SPARE_A && kind != K_SPARE_B) sent++;
      end
    end
  endtask

  task automatic run_directed();
    request_t r;
    for (int i = 0; i < SLOTS + 1; i++) begin
      r = noise_request(K_CREATE);
      if (i % 3 == 0) r.event_type = RENDER_TYPE_RESET;
      else if (i == 1) r.event_type = '0;
      else if (i == 4) r.event_type = {TYPE_W{1'b1}};
      else r.event_type = TYPE_W'(i + 16);
      if (i == 0 || i == 5) r.event_id = 32'h8000_0000;
      else if (i == 1) r.event_id = 32'h7FFF_FFFF;
      else if (i == 2) r.event_id = 32'hFFFF_FFFF;
      else r.event_id = 32'(i * 97);
      if (i == 2) begin
        r.now = 32'hFFFF_FFFF;
        r.delay = 32'hFFFF_FFFF;
      end else if (i == 3) begin
        r.now = 32'hFFFF_FFF0;
        r.delay = 32'h20;
      end else begin
        r.now = 32'(i);
        r.delay = (i % 2) ? 32'(i * 3) : '0;
      end
      send_request(r);
    end
    r = noise_request(K_FIND);
    r.event_id = 32'h8000_0000;
    send_request(r);
    r.event_id = 32'h1234_5678;
    send_request(r);
    r = noise_request(K_FREE);
    r.slot_index = SIDX_W'(SLOTS - 1);
    send_request(r);
    send_request(r);
    r = noise_request(K_PROC_RENDER);
    r.now = '0;
    send_request(r);
    r = noise_request(K_PROC_NORMAL);
    r.now = 32'hFFFF_FFFF;
    send_request(r);
    send_request(noise_request(K_CLEAR));
    send_request(noise_request(K_SPARE_A));
    send_request(noise_request(K_SPARE_B));
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= K_CREATE;
    in_ch.event_type <= '0;
    in_ch.event_id <= '0;
    in_ch.delay <= '0;
    in_ch.now <= '0;
    in_ch.slot_index <= '0;
    snd_idle_pct = 32;
    rcv_idle_pct = 49;
    tick = $urandom_range(0, 100000);
    id_pool[0] = 32'h8000_0000;
    id_pool[1] = 32'h7FFF_FFFF;
    id_pool[2] = '0;
    id_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) id_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();
    write_render_type('0);
    run_random(55);
    drain();

    snd_idle_pct = 49;
    rcv_idle_pct = 32;
    write_render_type({TYPE_W{1'b1}});
    run_random(55);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_render_type(TYPE_W'($urandom_range(2, 254)));
    run_random(55);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
src/etimer_pkg.sv
src/etimer_if.sv
src/etimer_ram.sv
src/etimer_ctrl.sv
src/etimer_dp.sv
src/event_timer_table_top.sv
src/etimer_checker.sv
test/tb_top.sv
